// File: hdl/pgpm_pkg.sv
`timescale 1ns / 1ps

package pgpm_pkg;

    localparam int SAMPLE_W = 32;
    localparam int GAIN_W   = 24;
    localparam int FUNC_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int GAIN_FRAC_BITS_DEF = 16;

    // sample width codes
    localparam logic [1:0] WIDTH_8    = 2'd0;
    localparam logic [1:0] WIDTH_16   = 2'd1;
    localparam logic [1:0] WIDTH_32   = 2'd2;
    localparam logic [1:0] WIDTH_NONE = 2'd3;

    // item kinds
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REPORT = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LITTLE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_EN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_EN  = 3'd5;

    localparam logic [GAIN_W-1:0] GAIN_UNITY = 24'd65536;

    // sign and magnitude of a decoded sample
    typedef struct packed {
        logic                neg;
        logic [SAMPLE_W-1:0] mag;
    } mag_t;

    function automatic logic [SAMPLE_W-1:0] width_mask(input logic [1:0] code);
        logic [SAMPLE_W-1:0] m;
        case (code)
            WIDTH_8:  m = 32'h0000_00ff;
            WIDTH_16: m = 32'h0000_ffff;
            default:  m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

    // memory order <-> numeric word; byte swap is its own inverse
    function automatic logic [SAMPLE_W-1:0] order_bytes(input logic [SAMPLE_W-1:0] w,
                                                        input logic [1:0] code,
                                                        input logic little);
        logic [SAMPLE_W-1:0] r;
        r = w & width_mask(code);
        if (!little)
        begin
            case (code)
                WIDTH_16: r = {16'h0000, w[7:0], w[15:8]};
                WIDTH_32: r = {w[7:0], w[15:8], w[23:16], w[31:24]};
                default:  r = w & width_mask(code);
            endcase
        end
        return r;
    endfunction

    function automatic logic top_bit(input logic [SAMPLE_W-1:0] w, input logic [1:0] code);
        logic b;
        case (code)
            WIDTH_8:  b = w[7];
            WIDTH_16: b = w[15];
            default:  b = w[31];
        endcase
        return b;
    endfunction

    // unsigned samples use the offset mapping 2*(u-M) above the base, 2*u below
    function automatic mag_t decode_word(input logic [SAMPLE_W-1:0] word,
                                         input logic [1:0] code,
                                         input logic sgn);
        mag_t                r;
        logic [SAMPLE_W-1:0] mask;
        logic [SAMPLE_W-1:0] w;
        logic [SAMPLE_W-1:0] d;
        logic                half;
        mask = width_mask(code);
        w    = word & mask;
        half = top_bit(w, code);
        d    = mask - w;
        if (sgn)
        begin
            r.neg = half;
            r.mag = half ? ((32'd0 - w) & mask) : w;
        end
        else if (half)
        begin
            r.neg = (d != 32'd0);
            r.mag = {d[SAMPLE_W-2:0], 1'b0};
        end
        else
        begin
            r.neg = 1'b0;
            r.mag = {w[SAMPLE_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // val: low bits of the scaled magnitude, h_nz: magnitude/2 is nonzero
    function automatic logic [SAMPLE_W-1:0] encode_value(input logic neg,
                                                         input logic [SAMPLE_W:0] val,
                                                         input logic h_nz,
                                                         input logic [1:0] code,
                                                         input logic sgn);
        logic [SAMPLE_W-1:0] mask;
        logic [SAMPLE_W-1:0] h;
        logic [SAMPLE_W-1:0] r;
        mask = width_mask(code);
        h    = val[SAMPLE_W:1];
        if (sgn)
            r = neg ? (32'd0 - val[SAMPLE_W-1:0]) : val[SAMPLE_W-1:0];
        else
            r = (neg && h_nz) ? (mask - h) : h;
        return r & mask;
    endfunction

    function automatic logic [SAMPLE_W-1:0] peak_limit(input logic [1:0] code,
                                                       input logic sgn);
        logic [SAMPLE_W-1:0] m;
        m = width_mask(code);
        return sgn ? (m >> 1) : m;
    endfunction

endpackage

// File: hdl/pcm_gain_and_peak_meter.sv
// PCM gain stage with running peak meter.
// An accepted input request goes through the input register, then the result register, to its result;
// one request per cycle sustained while m_tready is held high; a single
// 32x24 gain multiplier sits between the two registers. A reserved func code gives no result.
// Reset (rst_n low, asynchronous): pipeline empty, peak cleared, registers to defaults.
`timescale 1ns / 1ps

module pcm_gain_and_peak_meter
    import pgpm_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,   // [31:0] sample_raw
    input  logic [FUNC_W-1:0]     s_tuser,   // [1:0] func

    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [2*SAMPLE_W-1:0] m_tdata,   // [31:0] sample_out, [63:32] peak_level
    output logic                  m_tuser,   // [0] peak_report

    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PROD_W = SAMPLE_W + GAIN_W;

    // ---------------- configuration ----------------
    logic [1:0]        width_code_reg;
    logic              is_signed_reg;
    logic              little_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic              gain_en_reg;
    logic              level_en_reg;

    // never busy; the user must write only while the pipeline is empty, the block does not enforce it
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_code_reg <= WIDTH_16;
            is_signed_reg  <= 1'b1;
            little_reg     <= 1'b1;
            gain_reg       <= GAIN_UNITY;
            gain_en_reg    <= 1'b1;
            level_en_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WIDTH:    width_code_reg <= cfg_data[1:0];
                REG_SIGNED:   is_signed_reg  <= cfg_data[0];
                REG_LITTLE:   little_reg     <= cfg_data[0];
                REG_GAIN:     gain_reg       <= cfg_data[GAIN_W-1:0];
                REG_GAIN_EN:  gain_en_reg    <= cfg_data[0];
                REG_LEVEL_EN: level_en_reg   <= cfg_data[0];
                default:      ;   // writes beyond the map are dropped
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic                in_valid_reg;
    logic [FUNC_W-1:0]   in_func_reg;
    logic [SAMPLE_W-1:0] in_raw_reg;

    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] out_sample_reg;
    logic [SAMPLE_W-1:0] out_peak_reg;
    logic                out_report_reg;

    logic [SAMPLE_W-1:0] peak_reg;

    logic advance;   // result register can take the next value
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_func_reg <= s_tuser;
            in_raw_reg  <= s_tdata;
        end
    end

    // ---------------- datapath ----------------
    logic [SAMPLE_W-1:0] word_in;     // numeric word of the incoming sample
    mag_t                dec_in;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W-1:0]   scaled;
    logic                h_nz;
    logic [SAMPLE_W-1:0] enc_word;    // numeric word after gain
    logic [SAMPLE_W-1:0] word_out;    // numeric word of the outgoing sample
    mag_t                dec_out;
    logic [SAMPLE_W-1:0] meas_mag;
    logic [SAMPLE_W-1:0] meas_clip;
    logic [SAMPLE_W-1:0] limit;
    logic                fmt_ok;
    logic                meas_hit;

    logic [SAMPLE_W-1:0] sample_next;
    logic [SAMPLE_W-1:0] peak_next;
    logic                out_valid_next;

    always_comb
    begin
        fmt_ok  = (width_code_reg != WIDTH_NONE);
        word_in = order_bytes(in_raw_reg, width_code_reg, little_reg);
        dec_in  = decode_word(word_in, width_code_reg, is_signed_reg);

        // magnitude times gain, truncated toward zero
        prod   = PROD_W'(dec_in.mag) * PROD_W'(gain_reg);
        scaled = prod >> GAIN_FRAC_BITS;
        h_nz   = |scaled[PROD_W-1:1];
        enc_word = encode_value(dec_in.neg, scaled[SAMPLE_W:0], h_nz,
                                width_code_reg, is_signed_reg);

        // with gain off the outgoing word equals the incoming one
        word_out = gain_en_reg ? enc_word : word_in;
        dec_out  = decode_word(word_out, width_code_reg, is_signed_reg);

        // peak is taken before gain on reads, after gain on writes
        meas_mag  = (in_func_reg == FUNC_WRITE) ? dec_out.mag : dec_in.mag;
        limit     = peak_limit(width_code_reg, is_signed_reg);
        meas_clip = (meas_mag > limit) ? limit : meas_mag;
        meas_hit  = level_en_reg && fmt_ok && (meas_clip > peak_reg);

        peak_next   = peak_reg;
        sample_next = in_raw_reg;
        case (in_func_reg)
            FUNC_READ, FUNC_WRITE:
            begin
                if (!fmt_ok)
                    sample_next = in_raw_reg;   // unsupported width: raw passthrough
                else if (gain_en_reg)
                    sample_next = order_bytes(enc_word, width_code_reg, little_reg);
                else
                    sample_next = in_raw_reg & width_mask(width_code_reg);
                if (meas_hit)
                    peak_next = meas_clip;
            end
            FUNC_REPORT:
            begin
                sample_next = '0;
                peak_next   = '0;
            end
            default:
            begin
                sample_next = in_raw_reg;
                peak_next   = peak_reg;
            end
        endcase

        out_valid_next = in_valid_reg && (in_func_reg != FUNC_NONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            peak_reg      <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= out_valid_next;
            if (in_valid_reg)
                peak_reg <= peak_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_sample_reg <= sample_next;
            // a report shows the peak held before clearing
            out_peak_reg   <= (in_func_reg == FUNC_REPORT) ? peak_reg : peak_next;
            out_report_reg <= (in_func_reg == FUNC_REPORT);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_peak_reg, out_sample_reg};
    assign m_tuser  = out_report_reg;

    // ---------------- assertions ----------------
    a_report_zero_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[SAMPLE_W-1:0] == '0))
        else $error("report result carries a nonzero sample");

    a_report_clears_peak: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid_reg && (in_func_reg == FUNC_REPORT)) |=> (peak_reg == '0))
        else $error("peak not cleared after report");

    a_peak_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid_reg && (in_func_reg != FUNC_REPORT))
            |=> (peak_reg >= $past(peak_reg)))
        else $error("peak decreased without a report");

endmodule
